// File: rtl/core/sector_cache_directory_lru_top_defines.svh
// Assertion macros for the sector cache directory.
// Included by the top level; depends on nothing else.
`ifndef SECTOR_CACHE_DIRECTORY_LRU_TOP_DEFINES_SVH
`define SECTOR_CACHE_DIRECTORY_LRU_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sector cache directory: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sector cache directory: next-cycle check failed");

`endif

// File: rtl/core/scd_pkg.sv
// Shared types, codes and defaults for the sector cache directory.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package scd_pkg;

    localparam int ENTRIES_DEF     = 64;
    localparam int SECTOR_BITS_DEF = 32;

    localparam logic [2:0] MODE_ACQUIRE = 3'd0;
    localparam logic [2:0] MODE_RELEASE = 3'd1;
    localparam logic [2:0] MODE_EVICTED = 3'd2;
    localparam logic [2:0] MODE_FIND    = 3'd3;
    localparam logic [2:0] MODE_CLEAN   = 3'd4;

    localparam logic [3:0] ST_HIT     = 4'd0;
    localparam logic [3:0] ST_LOAD    = 4'd1;
    localparam logic [3:0] ST_WB      = 4'd2;
    localparam logic [3:0] ST_BUSY    = 4'd3;
    localparam logic [3:0] ST_EVWAIT  = 4'd4;
    localparam logic [3:0] ST_NONE    = 4'd5;
    localparam logic [3:0] ST_DIRTY   = 4'd6;
    localparam logic [3:0] ST_NODIRTY = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] sector;
        logic        is_meta;
        logic [5:0]  slot;
        logic        dirty;
    } t_req;

    typedef struct packed {
        logic [3:0]  status;
        logic [5:0]  slot_out;
        logic [31:0] writeback_sector;
        logic [31:0] access_total;
        logic [31:0] hit_total;
    } t_rsp;

    typedef struct packed {
        logic accept;
        logic scan;
        logic apply;
    } t_scd_cmd;

    typedef struct packed {
        logic need_scan;
        logic last_pos;
    } t_scd_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_APPLY
    } t_state;

endpackage
`default_nettype wire

// File: rtl/core/scd_ctrl.sv
// Controller state machine for the sector cache directory.
// Depends on scd_pkg; drives the datapath through t_scd_cmd.
`default_nettype none
module scd_ctrl
    import scd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_scd_sts i_sts,
    output t_scd_cmd      o_cmd,
    output logic          o_busy
);

    t_state r_state;
    t_state n_state;
    logic   r_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= (r_state == S_DRAIN);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_DECIDE;
            S_DECIDE: n_state = i_sts.need_scan ? S_SCAN : S_APPLY;
            S_SCAN:   if (i_sts.last_pos) n_state = S_DRAIN;
            S_DRAIN:  if (r_drain) n_state = S_APPLY;
            S_APPLY:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_start;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.apply  = (r_state == S_APPLY);
        o_busy       = (r_state != S_IDLE);
    end

endmodule
`default_nettype wire

// File: rtl/core/scd_datapath.sv
// Datapath of the sector cache directory: tag, evicting-tag and LRU memories,
// slot marks, the scan pipeline, counters and the response register.
// Depends on scd_pkg; commanded by scd_ctrl.
`default_nettype none
module scd_datapath
    import scd_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_req     i_req,
    input  wire t_scd_cmd i_cmd,
    output t_scd_sts      o_sts,
    output t_rsp          o_rsp,
    output logic          o_strobe
);

    localparam int IW = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
    localparam int SB = SECTOR_BITS;
    localparam logic [SB-1:0] NONE_TAG = {SB{1'b1}};
    localparam logic [IW-1:0] LAST_POS = IW'(ENTRIES - 1);

    logic [SB-1:0] r_tag_mem [ENTRIES];
    logic [SB-1:0] r_ev_mem  [ENTRIES];
    logic [IW-1:0] r_lru_mem [ENTRIES];

    logic [ENTRIES-1:0] r_tag_v;
    logic [ENTRIES-1:0] r_ev_v;
    logic [ENTRIES-1:0] r_lru_v;
    logic [ENTRIES-1:0] r_in_use;
    logic [ENTRIES-1:0] r_dirty_m;
    logic [ENTRIES-1:0] r_meta_m;

    logic [2:0]    r_mode;
    logic [SB-1:0] r_sector;
    logic          r_is_meta;
    logic [IW-1:0] r_slot;
    logic          r_slot_ok;
    logic          r_dirty_in;

    logic [IW-1:0] r_pos;
    logic          r_s1_v;
    logic [IW-1:0] r_s1_pos;
    logic [IW-1:0] r_lru_q;
    logic          r_lru_vq;
    logic          r_s2_v;
    logic [IW-1:0] r_s2_slot;
    logic [SB-1:0] r_tag_q;
    logic          r_tag_vq;
    logic [SB-1:0] r_ev_q;
    logic          r_ev_vq;

    logic          r_fnd;
    logic          r_fhit;
    logic          r_fbusy;
    logic [IW-1:0] r_fs;
    logic [SB-1:0] r_ftag;
    logic          r_hd;
    logic [IW-1:0] r_ds;
    logic [SB-1:0] r_dtag;
    logic          r_hm;
    logic [IW-1:0] r_ms;
    logic [SB-1:0] r_mtag;
    logic          r_mv_found;

    logic [31:0] r_acc;
    logic [31:0] r_hit;
    t_rsp        r_rsp;
    logic        r_strobe;

    logic          is_move;
    logic [IW-1:0] d1;
    logic [SB-1:0] s2_tag;
    logic [SB-1:0] s2_ev;
    logic [IW-1:0] cand;
    logic [SB-1:0] cand_tag;

    logic [3:0]    ap_status;
    logic [IW-1:0] ap_idx;
    logic [IW-1:0] ap_slot;
    logic [SB-1:0] ap_wb;
    logic          ap_acc;
    logic          ap_hit;
    logic          ap_set_use;
    logic          ap_clr_use;
    logic          ap_set_dirty;
    logic          ap_clr_dirty;
    logic          ap_meta_we;
    logic          ap_tag_we;
    logic          ap_ev_set;
    logic          ap_ev_clr;
    logic          ap_lru_last;

    logic          lru_we;
    logic [IW-1:0] lru_wa;
    logic [IW-1:0] lru_wd;
    logic [31:0]   n_acc;
    logic [31:0]   n_hit;

    assign is_move  = ((r_mode == MODE_RELEASE) || (r_mode == MODE_CLEAN)) && r_slot_ok;
    assign d1       = r_lru_vq ? r_lru_q : r_s1_pos;
    assign s2_tag   = r_tag_vq ? r_tag_q : NONE_TAG;
    assign s2_ev    = r_ev_vq ? r_ev_q : NONE_TAG;
    assign cand     = r_hd ? r_ds : r_ms;
    assign cand_tag = r_hd ? r_dtag : r_mtag;

    assign o_sts.need_scan = (r_mode == MODE_ACQUIRE) || (r_mode == MODE_FIND) || is_move;
    assign o_sts.last_pos  = (r_pos == LAST_POS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode     <= i_req.mode;
            r_sector   <= SB'(i_req.sector);
            r_is_meta  <= i_req.is_meta;
            r_slot     <= IW'(i_req.slot);
            r_slot_ok  <= ({26'd0, i_req.slot} < 32'(ENTRIES));
            r_dirty_in <= i_req.dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lru_q   <= r_lru_mem[r_pos];
        r_lru_vq  <= r_lru_v[r_pos];
        r_s1_pos  <= r_pos;
        r_tag_q   <= r_tag_mem[d1];
        r_tag_vq  <= r_tag_v[d1];
        r_ev_q    <= r_ev_mem[d1];
        r_ev_vq   <= r_ev_v[d1];
        r_s2_slot <= d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.scan;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pos      <= '0;
            r_fnd      <= 1'b0;
            r_hd       <= 1'b0;
            r_hm       <= 1'b0;
            r_mv_found <= 1'b0;
        end else begin
            if (i_cmd.scan) r_pos <= r_pos + 1'b1;
            if (r_s1_v && is_move && !r_mv_found && (d1 == r_slot)) r_mv_found <= 1'b1;
            if (r_s2_v && !r_fnd) begin
                if (r_mode == MODE_ACQUIRE) begin
                    if (s2_tag == r_sector) begin
                        r_fnd   <= 1'b1;
                        r_fhit  <= 1'b1;
                        r_fs    <= r_s2_slot;
                        r_fbusy <= r_in_use[r_s2_slot];
                    end else if (s2_ev == r_sector) begin
                        r_fnd  <= 1'b1;
                        r_fhit <= 1'b0;
                        r_fs   <= r_s2_slot;
                    end else if (!r_in_use[r_s2_slot]) begin
                        if (r_meta_m[r_s2_slot]) begin
                            if (!r_hm) begin
                                r_hm   <= 1'b1;
                                r_ms   <= r_s2_slot;
                                r_mtag <= s2_tag;
                            end
                        end else if (!r_hd) begin
                            r_hd   <= 1'b1;
                            r_ds   <= r_s2_slot;
                            r_dtag <= s2_tag;
                        end
                    end
                end else if (r_mode == MODE_FIND) begin
                    if (r_dirty_m[r_s2_slot] && (s2_ev == NONE_TAG)) begin
                        r_fnd   <= 1'b1;
                        r_fs    <= r_s2_slot;
                        r_fbusy <= r_in_use[r_s2_slot];
                        r_ftag  <= s2_tag;
                    end
                end
            end
        end
    end

    always_comb begin
        ap_status    = ST_DONE;
        ap_idx       = r_slot;
        ap_slot      = '0;
        ap_wb        = '0;
        ap_acc       = 1'b0;
        ap_hit       = 1'b0;
        ap_set_use   = 1'b0;
        ap_clr_use   = 1'b0;
        ap_set_dirty = 1'b0;
        ap_clr_dirty = 1'b0;
        ap_meta_we   = 1'b0;
        ap_tag_we    = 1'b0;
        ap_ev_set    = 1'b0;
        ap_ev_clr    = 1'b0;
        ap_lru_last  = 1'b0;
        if (r_mode == MODE_ACQUIRE) begin
            ap_acc = 1'b1;
            if (r_sector == NONE_TAG) begin
                ap_status = ST_NONE;
            end else if (r_fnd) begin
                ap_idx  = r_fs;
                ap_slot = r_fs;
                if (r_fhit) begin
                    ap_hit = 1'b1;
                    if (r_fbusy) begin
                        ap_status = ST_BUSY;
                    end else begin
                        ap_set_use = 1'b1;
                        ap_status  = ST_HIT;
                    end
                end else begin
                    ap_status = ST_EVWAIT;
                end
            end else if (r_hd || r_hm) begin
                ap_idx     = cand;
                ap_slot    = cand;
                ap_set_use = 1'b1;
                ap_meta_we = 1'b1;
                ap_tag_we  = 1'b1;
                if (r_dirty_m[cand]) begin
                    ap_ev_set = 1'b1;
                    ap_wb     = cand_tag;
                    ap_status = ST_WB;
                end else begin
                    ap_status = ST_LOAD;
                end
            end else begin
                ap_status = ST_NONE;
            end
        end else if (r_mode == MODE_FIND) begin
            if (r_fnd) begin
                ap_idx  = r_fs;
                ap_slot = r_fs;
                if (r_fbusy) begin
                    ap_status = ST_BUSY;
                end else begin
                    ap_set_use = 1'b1;
                    ap_wb      = r_ftag;
                    ap_status  = ST_DIRTY;
                end
            end else begin
                ap_status = ST_NODIRTY;
            end
        end else if (r_slot_ok) begin
            if (r_mode == MODE_RELEASE) begin
                ap_clr_use   = 1'b1;
                ap_set_dirty = r_dirty_in;
                ap_lru_last  = 1'b1;
            end else if (r_mode == MODE_EVICTED) begin
                ap_ev_clr    = 1'b1;
                ap_clr_dirty = 1'b1;
            end else if (r_mode == MODE_CLEAN) begin
                ap_clr_use   = 1'b1;
                ap_clr_dirty = 1'b1;
                ap_lru_last  = 1'b1;
            end
        end
    end

    always_comb begin
        if (r_s1_v && is_move && r_mv_found) begin
            lru_we = 1'b1;
            lru_wa = r_s1_pos - 1'b1;
            lru_wd = d1;
        end else begin
            lru_we = i_cmd.apply && ap_lru_last;
            lru_wa = LAST_POS;
            lru_wd = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lru_we) r_lru_mem[lru_wa] <= lru_wd;
        if (i_cmd.apply && ap_tag_we) r_tag_mem[ap_idx] <= r_sector;
        if (i_cmd.apply && ap_ev_set) r_ev_mem[ap_idx] <= cand_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_v   <= '0;
            r_ev_v    <= '0;
            r_lru_v   <= '0;
            r_in_use  <= '0;
            r_dirty_m <= '0;
            r_meta_m  <= '0;
        end else begin
            if (lru_we) r_lru_v[lru_wa] <= 1'b1;
            if (i_cmd.apply) begin
                if (ap_tag_we)    r_tag_v[ap_idx]   <= 1'b1;
                if (ap_ev_set)    r_ev_v[ap_idx]    <= 1'b1;
                if (ap_ev_clr)    r_ev_v[ap_idx]    <= 1'b0;
                if (ap_set_use)   r_in_use[ap_idx]  <= 1'b1;
                if (ap_clr_use)   r_in_use[ap_idx]  <= 1'b0;
                if (ap_set_dirty) r_dirty_m[ap_idx] <= 1'b1;
                if (ap_clr_dirty) r_dirty_m[ap_idx] <= 1'b0;
                if (ap_meta_we)   r_meta_m[ap_idx]  <= r_is_meta;
            end
        end
    end

    assign n_acc = r_acc + {31'd0, ap_acc};
    assign n_hit = r_hit + {31'd0, ap_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_hit    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.apply;
            if (i_cmd.apply) begin
                r_acc <= n_acc;
                r_hit <= n_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_rsp.status           <= ap_status;
            r_rsp.slot_out         <= 6'(ap_slot);
            r_rsp.writeback_sector <= 32'(ap_wb);
            r_rsp.access_total     <= n_acc;
            r_rsp.hit_total        <= n_hit;
        end
    end

    assign o_rsp    = r_rsp;
    assign o_strobe = r_strobe;

endmodule
`default_nettype wire

// File: rtl/core/sector_cache_directory_lru_top.sv
// Top level of the sector cache directory with LRU replacement.
// Depends on scd_pkg, scd_ctrl, scd_datapath and the assertion macro header.
//
//   Channel   Signals                      Transfer
//   request   start, busy, i_req           start high while busy low
//   result    o_strobe, o_rsp              one cycle, cannot be held off
//
// Acquire, find dirty and, for a slot in range, release and clean release
// walk the LRU list through the single read port of the list memory, one
// position a cycle, from the decide state through scan and drain to apply.
// Evict done and requests with no effect go from decide straight to apply.
// Reset is synchronous; the directory is usable in the cycle after it.
// The result is registered and shown for one cycle as busy drops.
`default_nettype none
`include "sector_cache_directory_lru_top_defines.svh"
module sector_cache_directory_lru_top
    import scd_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_strobe,
    output t_rsp      o_rsp
);

    t_scd_cmd ctl_cmd;
    t_scd_sts dp_sts;

    scd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (ctl_cmd),
        .o_busy  (busy)
    );

    scd_datapath #(
        .ENTRIES     (ENTRIES),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (ctl_cmd),
        .o_sts    (dp_sts),
        .o_rsp    (o_rsp),
        .o_strobe (o_strobe)
    );

    `SCD_ASSERT_NXT(a_apply_gives_result, i_clk, i_rst_n, ctl_cmd.apply, o_strobe)
    `SCD_ASSERT_NXT(a_accept_sets_busy, i_clk, i_rst_n, start && !busy, busy)
    `SCD_ASSERT_IMP(a_result_when_idle, i_clk, i_rst_n, o_strobe, !busy)
    `SCD_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_strobe, o_rsp.status <= ST_DONE)

endmodule
`default_nettype wire

// File: tb/sv/scd_checker.sv
// Checker for the sector cache directory: watches requests and results,
// predicts each result from its own copy of the directory and compares.
// Depends on scd_pkg.
`default_nettype none
module scd_checker
    import scd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  wire t_req i_req,
    input  wire logic i_strobe,
    input  wire t_rsp i_rsp,
    output int        o_errors,
    output int        o_pending
);
    localparam int N = 64;
    localparam logic [31:0] NO_SECT = 32'hFFFF_FFFF;

    logic [31:0] tag_q [N];
    logic [31:0] evict_q [N];
    logic        used_q [N];
    logic        dirty_q [N];
    logic        meta_q [N];
    logic [5:0]  order_q [N];
    logic [31:0] acc_q;
    logic [31:0] hit_q;
    t_rsp        expected_rsp_q [$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        o_errors++;
    endtask

    task automatic promote_slot(input logic [5:0] s);
        int p;
        p = 0;
        while (p < N && order_q[p] != s) p++;
        for (int i = p; i + 1 < N; i++) order_q[i] = order_q[i + 1];
        order_q[N - 1] = s;
    endtask

    function automatic void directory_reset();
        for (int i = 0; i < N; i++) begin
            tag_q[i] = NO_SECT;
            evict_q[i] = NO_SECT;
            used_q[i] = 0;
            dirty_q[i] = 0;
            meta_q[i] = 0;
            order_q[i] = 6'(i);
        end
        acc_q = 0;
        hit_q = 0;
    endfunction

    task automatic predict_directory(input t_req r, output t_rsp e);
        logic found, have_d, have_m;
        logic [5:0] ds, ms, s;
        e = '0;
        e.status = ST_DONE;
        found = 0;
        have_d = 0;
        have_m = 0;
        ds = 0;
        ms = 0;
        if (r.mode == MODE_ACQUIRE) begin
            acc_q++;
            if (r.sector == NO_SECT) begin
                e.status = ST_NONE;
            end else begin
                for (int i = 0; i < N && !found; i++) begin
                    s = order_q[i];
                    if (tag_q[s] == r.sector) begin
                        found = 1;
                        hit_q++;
                        e.slot_out = s;
                        if (used_q[s]) begin
                            e.status = ST_BUSY;
                        end else begin
                            used_q[s] = 1;
                            e.status = ST_HIT;
                        end
                    end else if (evict_q[s] == r.sector) begin
                        found = 1;
                        e.slot_out = s;
                        e.status = ST_EVWAIT;
                    end else if (!used_q[s]) begin
                        if (meta_q[s]) begin
                            if (!have_m) begin have_m = 1; ms = s; end
                        end else if (!have_d) begin
                            have_d = 1;
                            ds = s;
                        end
                    end
                end
                if (!found) begin
                    if (have_d || have_m) begin
                        s = have_d ? ds : ms;
                        used_q[s] = 1;
                        meta_q[s] = r.is_meta;
                        e.slot_out = s;
                        if (dirty_q[s]) begin
                            evict_q[s] = tag_q[s];
                            e.writeback_sector = tag_q[s];
                            e.status = ST_WB;
                        end else begin
                            e.status = ST_LOAD;
                        end
                        tag_q[s] = r.sector;
                    end else begin
                        e.status = ST_NONE;
                    end
                end
            end
        end else if (r.mode == MODE_FIND) begin
            e.status = ST_NODIRTY;
            for (int i = 0; i < N && !found; i++) begin
                s = order_q[i];
                if (dirty_q[s] && evict_q[s] == NO_SECT) begin
                    found = 1;
                    e.slot_out = s;
                    if (used_q[s]) begin
                        e.status = ST_BUSY;
                    end else begin
                        used_q[s] = 1;
                        e.status = ST_DIRTY;
                        e.writeback_sector = tag_q[s];
                    end
                end
            end
        end else if (r.mode == MODE_RELEASE) begin
            used_q[r.slot] = 0;
            if (r.dirty) dirty_q[r.slot] = 1;
            promote_slot(r.slot);
        end else if (r.mode == MODE_EVICTED) begin
            evict_q[r.slot] = NO_SECT;
            dirty_q[r.slot] = 0;
        end else if (r.mode == MODE_CLEAN) begin
            dirty_q[r.slot] = 0;
            used_q[r.slot] = 0;
            promote_slot(r.slot);
        end
        e.access_total = acc_q;
        e.hit_total = hit_q;
    endtask

    initial begin
        o_errors = 0;
        directory_reset();
    end

    assign o_pending = expected_rsp_q.size();

    always @(posedge i_clk) begin
        t_rsp e;
        if (!i_rst_n) begin
            directory_reset();
            expected_rsp_q.delete();
        end else begin
            if (i_strobe) begin
                if (expected_rsp_q.size() == 0) begin
                    report("unexpected result", 32'(i_rsp.status), 32'd0);
                end else begin
                    e = expected_rsp_q.pop_front();
                    if (i_rsp.status != e.status)
                        report("status", 32'(i_rsp.status), 32'(e.status));
                    if (i_rsp.slot_out != e.slot_out)
                        report("slot_out", 32'(i_rsp.slot_out), 32'(e.slot_out));
                    if (i_rsp.writeback_sector != e.writeback_sector)
                        report("writeback_sector", i_rsp.writeback_sector,
                               e.writeback_sector);
                    if (i_rsp.access_total != e.access_total)
                        report("access_total", i_rsp.access_total, e.access_total);
                    if (i_rsp.hit_total != e.hit_total)
                        report("hit_total", i_rsp.hit_total, e.hit_total);
                end
            end
            if (i_start && !i_busy) begin
                predict_directory(i_req, e);
                expected_rsp_q.push_back(e);
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench top for the sector cache directory: clock, reset, directed and
// random requests. Depends on scd_pkg, scd_checker and the block itself.
`default_nettype none
module tb
    import scd_pkg::*;
();

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_rsp o_rsp;
    int   errors;
    int   pending;
    int   cycles;
    logic [31:0] pool [16];

    sector_cache_directory_lru_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_strobe(o_strobe), .o_rsp(o_rsp)
    );

    scd_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_req(i_req), .i_strobe(o_strobe), .i_rsp(o_rsp),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 600000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [2:0] m, input logic [31:0] sec,
                                input logic meta, input logic [5:0] sl, input logic d);
        t_req r;
        r.mode = m;
        r.sector = sec;
        r.is_meta = meta;
        r.slot = sl;
        r.dirty = d;
        start <= 1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        start <= 0;
        @(posedge i_clk);
    endtask

    task automatic pause_random();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic random_request();
        int k;
        logic [31:0] sec;
        k = $urandom_range(0, 99);
        sec = ($urandom_range(0, 3) == 0) ? $urandom() : pool[$urandom_range(0, 15)];
        if (k < 45)
            send_request(MODE_ACQUIRE, sec, 1'($urandom()), 6'($urandom()), 1'($urandom()));
        else if (k < 70)
            send_request(MODE_RELEASE, $urandom(), 1'($urandom()), 6'($urandom()),
                         1'($urandom()));
        else if (k < 80)
            send_request(MODE_EVICTED, $urandom(), 1'($urandom()), 6'($urandom()),
                         1'($urandom()));
        else if (k < 88)
            send_request(MODE_FIND, $urandom(), 1'($urandom()), 6'($urandom()),
                         1'($urandom()));
        else if (k < 96)
            send_request(MODE_CLEAN, $urandom(), 1'($urandom()), 6'($urandom()),
                         1'($urandom()));
        else
            send_request(3'($urandom_range(5, 7)), $urandom(), 1'($urandom()),
                         6'($urandom()), 1'($urandom()));
    endtask

    initial begin
        int budget;
        i_rst_n = 0;
        start = 0;
        i_req = '0;
        for (int i = 0; i < 16; i++) pool[i] = $urandom();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_request(MODE_ACQUIRE, 32'h0, 0, 0, 0);
        send_request(MODE_ACQUIRE, 32'h0, 0, 0, 0);
        send_request(MODE_ACQUIRE, 32'hFFFF_FFFF, 0, 0, 0);
        send_request(MODE_ACQUIRE, 32'hFFFF_FFFE, 1, 6'd63, 1);
        send_request(MODE_RELEASE, 0, 0, 6'd0, 1);
        send_request(MODE_RELEASE, 0, 0, 6'd1, 1);
        send_request(MODE_ACQUIRE, 32'h0, 0, 0, 0);
        send_request(MODE_FIND, 0, 0, 0, 0);
        send_request(MODE_RELEASE, 0, 0, 6'd0, 0);
        send_request(MODE_FIND, 0, 0, 0, 0);
        send_request(MODE_RELEASE, 0, 0, 6'd0, 1);
        for (int i = 0; i < 3; i++) send_request(MODE_ACQUIRE, 32'h100 + i, 1, 0, 0);
        send_request(MODE_ACQUIRE, 32'hFFFF_FFFE, 0, 0, 0);
        send_request(MODE_EVICTED, 0, 0, 6'd1, 0);
        send_request(MODE_CLEAN, 0, 0, 6'd63, 0);
        send_request(MODE_FIND, 0, 0, 0, 0);
        send_request(3'd5, 32'hFFFF_FFFF, 1, 6'd63, 1);
        send_request(3'd7, 0, 0, 0, 0);

        // Fill every slot so that acquires run out of free slots.
        for (int i = 0; i < 66; i++) send_request(MODE_ACQUIRE, 32'h1000 + i, 1'(i & 1), 0, 0);
        while (pending != 0) @(posedge i_clk);
        repeat ($urandom_range(5, 40)) @(posedge i_clk);

        budget = 1500;
        while (budget > 0) begin
            if ($urandom_range(0, 2) != 0) random_request();
            else begin
                pause_random();
                random_request();
            end
            budget--;
        end

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/scd_pkg.sv
rtl/core/scd_ctrl.sv
rtl/core/scd_datapath.sv
rtl/core/sector_cache_directory_lru_top.sv
tb/sv/scd_checker.sv
tb/sv/tb.sv
